### rtl/rpa_pkg.sv
// ----------------------------------------------------------------------------
// rpa_pkg: register pool allocator shared types and constants
// Transfer payload structs, request codes, register indexes and the fixed
// priority orders used by the free-entry search of each pool.
// ----------------------------------------------------------------------------
package rpa_pkg;

	localparam int REGS_PER_POOL = 16;
	localparam int IDX_W         = $clog2(REGS_PER_POOL);
	localparam int GP_ORDER_LEN  = 15;
	localparam int VEC_ORDER_LEN = 16;

	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [REGS_PER_POOL-1:0] pool_bits_t;

	// request kinds
	localparam logic [1:0] KIND_ALLOC   = 2'd0;
	localparam logic [1:0] KIND_FREE    = 2'd1;
	localparam logic [1:0] KIND_RELEASE = 2'd2;

	// pool select
	localparam logic POOL_GP  = 1'b0;
	localparam logic POOL_VEC = 1'b1;

	// configuration register indexes
	localparam logic CFG_GP_RESERVED  = 1'b0;
	localparam logic CFG_VEC_RESERVED = 1'b1;

	// stack pointer entry of the general pool is always reserved
	localparam pool_bits_t GP_FORCED_RESERVED = 16'h0010;
	localparam pool_bits_t VEC_RESERVED_RESET = 16'h0000;

	localparam idx_t GP_ORDER [GP_ORDER_LEN] = '{
		4'd8, 4'd9, 4'd10, 4'd11, 4'd0, 4'd1, 4'd2, 4'd7,
		4'd6, 4'd12, 4'd13, 4'd14, 4'd15, 4'd3, 4'd5
	};

	localparam idx_t VEC_ORDER [VEC_ORDER_LEN] = '{
		4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
		4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7
	};

	typedef struct packed {
		logic [1:0] kind;
		logic       pool;
		idx_t       reg_index;
		logic       has_register;
	} req_t;

	typedef struct packed {
		idx_t       granted_index;
		logic       granted;
		pool_bits_t gp_allocated_now;
		pool_bits_t vec_allocated_now;
	} rsp_t;

endpackage

### rtl/register_pool_allocator_unit.sv
// ----------------------------------------------------------------------------
// register_pool_allocator_unit: two-pool bitmap register allocator
// Grants, frees and releases entries of a general and a vector pool of
// sixteen registers each, honoring per-pool reserved masks.
// ----------------------------------------------------------------------------
// The unit takes one request per clock while req_stall is low and returns
// one result per request through the request register and then the result
// register. Throughput is one request per cycle without stalls, set by the
// single processing stage that reads, updates and writes back the allocated
// bitmaps in the same cycle. The result register decouples the two sides: a
// request is still taken while a finished result waits on rsp_stall; the
// request side stalls only when the request stage and result register are
// full and rsp_stall is high. The user must write reserved masks through the
// cfg port while idle, unenforced; general mask bit 4 (stack pointer) stays set.
module register_pool_allocator_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  rpa_pkg::req_t         req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output rpa_pkg::rsp_t         rsp,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  rpa_pkg::pool_bits_t   cfg_data
);

	// request stage
	logic                req_valid_s1;
	rpa_pkg::req_t       req_s1;
	// result register
	logic                rsp_valid_s2;
	rpa_pkg::rsp_t       rsp_s2;
	// pool state and configuration
	rpa_pkg::pool_bits_t gp_alloc_q;
	rpa_pkg::pool_bits_t vec_alloc_q;
	rpa_pkg::pool_bits_t gp_resv_q;
	rpa_pkg::pool_bits_t vec_resv_q;

	logic                advance;
	rpa_pkg::pool_bits_t busy;
	rpa_pkg::pool_bits_t sel_alloc;
	rpa_pkg::pool_bits_t sel_alloc_next;
	rpa_pkg::pool_bits_t gp_alloc_next;
	rpa_pkg::pool_bits_t vec_alloc_next;
	logic                gp_found;
	rpa_pkg::idx_t       gp_pick;
	logic                vec_found;
	rpa_pkg::idx_t       vec_pick;
	logic                grant;
	rpa_pkg::idx_t       grant_idx;

	// move the request stage forward when the result register can take it
	assign advance   = req_valid_s1 && (!rsp_valid_s2 || !rsp_stall);
	assign req_stall = req_valid_s1 && !advance;
	assign rsp_valid = rsp_valid_s2;
	assign rsp       = rsp_s2;

	// search each pool's priority order for the first free, unreserved entry
	always_comb begin
		gp_found  = 1'b0;
		gp_pick   = '0;
		vec_found = 1'b0;
		vec_pick  = '0;
		for (int i = rpa_pkg::GP_ORDER_LEN - 1; i >= 0; i--) begin
			if (!(gp_alloc_q[rpa_pkg::GP_ORDER[i]] || gp_resv_q[rpa_pkg::GP_ORDER[i]]
					|| rpa_pkg::GP_FORCED_RESERVED[rpa_pkg::GP_ORDER[i]])) begin
				gp_found = 1'b1;
				gp_pick  = rpa_pkg::GP_ORDER[i];
			end
		end
		for (int i = rpa_pkg::VEC_ORDER_LEN - 1; i >= 0; i--) begin
			if (!(vec_alloc_q[rpa_pkg::VEC_ORDER[i]] || vec_resv_q[rpa_pkg::VEC_ORDER[i]])) begin
				vec_found = 1'b1;
				vec_pick  = rpa_pkg::VEC_ORDER[i];
			end
		end
	end

	// decide the grant and the new bitmap of the addressed pool
	always_comb begin
		if (req_s1.pool == rpa_pkg::POOL_VEC) begin
			sel_alloc = vec_alloc_q;
			busy      = vec_alloc_q | vec_resv_q;
		end else begin
			sel_alloc = gp_alloc_q;
			busy      = gp_alloc_q | gp_resv_q | rpa_pkg::GP_FORCED_RESERVED;
		end
		grant          = 1'b0;
		grant_idx      = '0;
		sel_alloc_next = sel_alloc;
		case (req_s1.kind)
			rpa_pkg::KIND_ALLOC: begin
				if (req_s1.has_register && !busy[req_s1.reg_index]) begin
					grant     = 1'b1;
					grant_idx = req_s1.reg_index;
				end else if (req_s1.pool == rpa_pkg::POOL_VEC) begin
					grant     = vec_found;
					grant_idx = vec_found ? vec_pick : '0;
				end else begin
					grant     = gp_found;
					grant_idx = gp_found ? gp_pick : '0;
				end
				if (grant) begin
					sel_alloc_next[grant_idx] = 1'b1;
				end
			end
			rpa_pkg::KIND_FREE: begin
				if (req_s1.has_register) begin
					sel_alloc_next[req_s1.reg_index] = 1'b0;
				end
			end
			rpa_pkg::KIND_RELEASE: begin
				sel_alloc_next = '0;
			end
			default: begin
				sel_alloc_next = sel_alloc;
			end
		endcase
		gp_alloc_next  = (req_s1.pool == rpa_pkg::POOL_GP) ? sel_alloc_next : gp_alloc_q;
		vec_alloc_next = (req_s1.pool == rpa_pkg::POOL_VEC) ? sel_alloc_next : vec_alloc_q;
	end

	// hold the request stage; load on each request transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			req_valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			req_s1 <= req;
		end
	end

	// update the result valid flag: set on advance, drop on result transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s2 <= 1'b0;
		end else if (advance) begin
			rsp_valid_s2 <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2.granted_index     <= grant_idx;
			rsp_s2.granted           <= grant;
			rsp_s2.gp_allocated_now  <= gp_alloc_next;
			rsp_s2.vec_allocated_now <= vec_alloc_next;
		end
	end

	// commit the bitmaps of each processed request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gp_alloc_q  <= '0;
			vec_alloc_q <= '0;
		end else if (advance) begin
			gp_alloc_q  <= gp_alloc_next;
			vec_alloc_q <= vec_alloc_next;
		end
	end

	// write reserved masks; keep the stack pointer reserved
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gp_resv_q  <= rpa_pkg::GP_FORCED_RESERVED;
			vec_resv_q <= rpa_pkg::VEC_RESERVED_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				rpa_pkg::CFG_GP_RESERVED: begin
					gp_resv_q <= cfg_data | rpa_pkg::GP_FORCED_RESERVED;
				end
				rpa_pkg::CFG_VEC_RESERVED: begin
					vec_resv_q <= cfg_data;
				end
				default: begin
					vec_resv_q <= vec_resv_q;
				end
			endcase
		end
	end

endmodule

### tb/rpa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_checker: result predictor and scoreboard for the register pool allocator
// Tracks both allocated bitmaps and reserved masks, predicts the result of
// every accepted request, and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module rpa_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_stall,
	input  rpa_pkg::req_t       req,
	input  logic                rsp_valid,
	input  logic                rsp_stall,
	input  rpa_pkg::rsp_t       rsp,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  rpa_pkg::pool_bits_t cfg_data,
	output int                  mismatch_count,
	output int                  results_owed
);

	localparam int MAX_REPORTS = 10;

	// search orders used when the preferred entry is absent or busy
	localparam rpa_pkg::idx_t GP_SEARCH [15] = '{
		4'd8, 4'd9, 4'd10, 4'd11, 4'd0, 4'd1, 4'd2, 4'd7,
		4'd6, 4'd12, 4'd13, 4'd14, 4'd15, 4'd3, 4'd5
	};
	localparam rpa_pkg::idx_t VEC_SEARCH [16] = '{
		4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
		4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7
	};

	rpa_pkg::pool_bits_t gp_alloc;
	rpa_pkg::pool_bits_t vec_alloc;
	rpa_pkg::pool_bits_t gp_resv;
	rpa_pkg::pool_bits_t vec_resv;
	rpa_pkg::rsp_t       predicted_results[$];

	// apply one request to the tracked bitmaps and return the expected result
	function automatic rpa_pkg::rsp_t predict_result(input rpa_pkg::req_t r);
		rpa_pkg::rsp_t       res;
		rpa_pkg::pool_bits_t busy;
		logic                found;
		int                  i;
		res   = '0;
		found = 1'b0;
		case (r.kind)
		rpa_pkg::KIND_ALLOC: begin
			if (r.pool == rpa_pkg::POOL_VEC) begin
				busy = vec_alloc | vec_resv;
			end else begin
				busy = gp_alloc | gp_resv | rpa_pkg::GP_FORCED_RESERVED;
			end
			if (r.has_register && !busy[r.reg_index]) begin
				res.granted_index = r.reg_index;
				found = 1'b1;
			end
			if (r.pool == rpa_pkg::POOL_VEC) begin
				for (i = 0; i < 16; i++) begin
					if (!found && !busy[VEC_SEARCH[i]]) begin
						res.granted_index = VEC_SEARCH[i];
						found = 1'b1;
					end
				end
			end else begin
				for (i = 0; i < 15; i++) begin
					if (!found && !busy[GP_SEARCH[i]]) begin
						res.granted_index = GP_SEARCH[i];
						found = 1'b1;
					end
				end
			end
			if (found) begin
				res.granted = 1'b1;
				if (r.pool == rpa_pkg::POOL_VEC) vec_alloc[res.granted_index] = 1'b1;
				else gp_alloc[res.granted_index] = 1'b1;
			end
		end
		rpa_pkg::KIND_FREE: begin
			if (r.has_register) begin
				if (r.pool == rpa_pkg::POOL_VEC) vec_alloc[r.reg_index] = 1'b0;
				else gp_alloc[r.reg_index] = 1'b0;
			end
		end
		rpa_pkg::KIND_RELEASE: begin
			if (r.pool == rpa_pkg::POOL_VEC) vec_alloc = '0;
			else gp_alloc = '0;
		end
		default: begin
		end
		endcase
		res.gp_allocated_now  = gp_alloc;
		res.vec_allocated_now = vec_alloc;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rpa_pkg::rsp_t want;
		if (!arst_n) begin
			gp_alloc  = '0;
			vec_alloc = '0;
			gp_resv   = rpa_pkg::GP_FORCED_RESERVED;
			vec_resv  = rpa_pkg::VEC_RESERVED_RESET;
			predicted_results.delete();
			results_owed   = 0;
			mismatch_count = 0;
		end else begin
			// compare an accepted result with the oldest prediction
			if (rsp_valid && !rsp_stall) begin
				if (predicted_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: result transfer with no request outstanding", $time);
				end else begin
					want = predicted_results.pop_front();
					if (rsp.granted_index !== want.granted_index ||
					    rsp.granted !== want.granted ||
					    rsp.gp_allocated_now !== want.gp_allocated_now ||
					    rsp.vec_allocated_now !== want.vec_allocated_now) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS) begin
							$write("%0t: result mismatch: expected idx=%0d granted=%0b ",
								$time, want.granted_index, want.granted);
							$display("gp=%04h vec=%04h, got idx=%0d granted=%0b gp=%04h vec=%04h",
								want.gp_allocated_now, want.vec_allocated_now,
								rsp.granted_index, rsp.granted,
								rsp.gp_allocated_now, rsp.vec_allocated_now);
						end
					end
				end
			end
			// track reserved masks; the stack pointer stays reserved
			if (cfg_we) begin
				if (cfg_index == rpa_pkg::CFG_GP_RESERVED)
					gp_resv = cfg_data | rpa_pkg::GP_FORCED_RESERVED;
				else vec_resv = cfg_data;
			end
			// predict each accepted request
			if (req_valid && !req_stall)
				predicted_results.push_back(predict_result(req));
			results_owed = predicted_results.size();
		end
	end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: register pool allocator testbench
// Drives directed and random allocate, free, release and unused-kind requests
// under several reserved-mask settings, with random result stalls and request
// gaps; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 50;

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_stall;
	rpa_pkg::req_t       req;
	logic                rsp_valid;
	logic                rsp_stall;
	rpa_pkg::rsp_t       rsp;
	logic                cfg_we;
	logic                cfg_index;
	rpa_pkg::pool_bits_t cfg_data;

	logic idle_on = 1'b1;
	logic req_taken;
	int   cycles = 0;
	int   mismatch_count;
	int   results_owed;

	register_pool_allocator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	rpa_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.req            (req),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.rsp            (rsp),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.results_owed   (results_owed)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// record request transfers at the edge for the driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) req_taken <= 1'b0;
		else req_taken <= req_valid & ~req_stall;
	end

	// abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// stall the result side in short random bursts
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 3) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(negedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	// hold one request until it transfers, then maybe leave a gap
	task automatic send_req(input logic [1:0] kind, input logic pool,
		input rpa_pkg::idx_t idx, input logic has_reg);
		req_valid <= 1'b1;
		req <= '{kind: kind, pool: pool, reg_index: idx, has_register: has_reg};
		do @(negedge clk); while (!req_taken);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
	endtask

	task automatic send_random();
		int         roll;
		logic [1:0] kind;
		roll = $urandom_range(0, 99);
		if (roll < 55) kind = rpa_pkg::KIND_ALLOC;
		else if (roll < 88) kind = rpa_pkg::KIND_FREE;
		else if (roll < 94) kind = rpa_pkg::KIND_RELEASE;
		else kind = KIND_UNUSED;
		send_req(kind, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
			1'($urandom_range(0, 1)));
	endtask

	// stop sending and wait out every outstanding result
	task automatic drain();
		req_valid <= 1'b0;
		do @(negedge clk); while (results_owed != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_masks(input rpa_pkg::pool_bits_t gp_mask,
		input rpa_pkg::pool_bits_t vec_mask);
		cfg_we    <= 1'b1;
		cfg_index <= rpa_pkg::CFG_GP_RESERVED;
		cfg_data  <= gp_mask;
		@(negedge clk);
		cfg_index <= rpa_pkg::CFG_VEC_RESERVED;
		cfg_data  <= vec_mask;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		rpa_pkg::pool_bits_t gp_mask;
		rpa_pkg::pool_bits_t vec_mask;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		cfg_we    = 1'b0;
		cfg_index = rpa_pkg::CFG_GP_RESERVED;
		cfg_data  = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset masks: preference, busy preference, stack pointer, frees, unused kind, release
		send_req(rpa_pkg::KIND_ALLOC,   rpa_pkg::POOL_GP,  4'd0,  1'b0);
		send_req(rpa_pkg::KIND_ALLOC,   rpa_pkg::POOL_GP,  4'd4,  1'b1);
		send_req(rpa_pkg::KIND_ALLOC,   rpa_pkg::POOL_GP,  4'd15, 1'b1);
		send_req(rpa_pkg::KIND_ALLOC,   rpa_pkg::POOL_GP,  4'd15, 1'b1);
		send_req(rpa_pkg::KIND_ALLOC,   rpa_pkg::POOL_VEC, 4'd0,  1'b1);
		send_req(rpa_pkg::KIND_ALLOC,   rpa_pkg::POOL_VEC, 4'd4,  1'b1);
		send_req(rpa_pkg::KIND_ALLOC,   rpa_pkg::POOL_VEC, 4'd15, 1'b0);
		send_req(rpa_pkg::KIND_FREE,    rpa_pkg::POOL_GP,  4'd15, 1'b1);
		send_req(rpa_pkg::KIND_FREE,    rpa_pkg::POOL_GP,  4'd9,  1'b0);
		send_req(rpa_pkg::KIND_FREE,    rpa_pkg::POOL_GP,  4'd4,  1'b1);
		send_req(rpa_pkg::KIND_FREE,    rpa_pkg::POOL_VEC, 4'd7,  1'b1);
		send_req(KIND_UNUSED,           rpa_pkg::POOL_VEC, 4'd15, 1'b1);
		send_req(rpa_pkg::KIND_RELEASE, rpa_pkg::POOL_GP,  4'd0,  1'b0);
		send_req(rpa_pkg::KIND_RELEASE, rpa_pkg::POOL_VEC, 4'd15, 1'b1);
		drain();

		// nearly full and full pools: exhaustion with and without preference
		set_masks(16'hFFEE, 16'hFFFF);
		send_req(rpa_pkg::KIND_ALLOC,   rpa_pkg::POOL_GP,  4'd4,  1'b1);
		send_req(rpa_pkg::KIND_ALLOC,   rpa_pkg::POOL_GP,  4'd0,  1'b1);
		send_req(rpa_pkg::KIND_ALLOC,   rpa_pkg::POOL_GP,  4'd0,  1'b0);
		send_req(rpa_pkg::KIND_ALLOC,   rpa_pkg::POOL_VEC, 4'd3,  1'b1);
		send_req(rpa_pkg::KIND_ALLOC,   rpa_pkg::POOL_VEC, 4'd0,  1'b0);
		send_req(rpa_pkg::KIND_FREE,    rpa_pkg::POOL_GP,  4'd0,  1'b1);
		send_req(rpa_pkg::KIND_ALLOC,   rpa_pkg::POOL_GP,  4'd0,  1'b1);
		send_req(rpa_pkg::KIND_RELEASE, rpa_pkg::POOL_GP,  4'd0,  1'b0);
		drain();

		// random requests under a new mask setting per phase
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
			0: begin
				gp_mask  = 16'h0000;
				vec_mask = 16'h0000;
			end
			1: begin
				gp_mask  = 16'hFFFF;
				vec_mask = 16'hFFFF;
			end
			4: begin
				gp_mask  = 16'h00FF;
				vec_mask = 16'hFF00;
			end
			2: begin
				gp_mask  = rpa_pkg::pool_bits_t'($urandom);
				vec_mask = rpa_pkg::pool_bits_t'($urandom);
			end
			default: begin
				gp_mask  = rpa_pkg::pool_bits_t'($urandom & $urandom);
				vec_mask = rpa_pkg::pool_bits_t'($urandom & $urandom);
			end
			endcase
			set_masks(gp_mask, vec_mask);
			idle_on = (phase % 4 != 3) && (phase != PHASES - 1);
			repeat (PHASE_ITEMS) send_random();
			drain();
		end

		repeat (10) @(negedge clk);
		if (mismatch_count == 0 && results_owed == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

### files.f
rtl/rpa_pkg.sv
rtl/register_pool_allocator_unit.sv
tb/rpa_checker.sv
tb/tb.sv
